// File: design/prq_pkg.sv
// shared types, opcodes, status codes and default sizes of the ready-queue scheduler
`timescale 1ns / 1ps

package prq_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_PUT      = 2'd0;
  localparam opcode_t OP_TAKE     = 2'd1;
  localparam opcode_t OP_SCHEDULE = 2'd2;
  localparam opcode_t OP_CHANGE   = 2'd3;

  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_ALREADY    = 2'd1;
  localparam status_t ST_NONE_READY = 2'd2;
  localparam status_t ST_NOT_HEAD   = 2'd3;

  localparam int DEF_THREADS    = 8;
  localparam int DEF_PRIORITIES = 16;

endpackage

// File: design/prq_if.sv
// valid/ready channel interfaces for scheduler requests and results
`timescale 1ns / 1ps

interface prq_req_if;
  import prq_pkg::*;

  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic [2:0]        thread_id;
  logic signed [4:0] new_priority;

  modport source (output valid, opcode, thread_id, new_priority, input ready);
  modport sink   (input valid, opcode, thread_id, new_priority, output ready);
endinterface

interface prq_rsp_if;
  import prq_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] chosen_thread;
  logic [3:0] old_priority;
  status_t    status;

  modport source (output valid, chosen_thread, old_priority, status, input ready);
  modport sink   (input valid, chosen_thread, old_priority, status, output ready);
endinterface

// File: design/priority_ready_queue_scheduler.sv
// fixed-priority fifo ready-queue scheduler built around three small synchronous memories
`timescale 1ns / 1ps

// channel | role   | payload                                     | accepted when
// req     | sink   | opcode, thread_id, new_priority             | valid && ready
// rsp     | source | chosen_thread, old_priority, status         | valid && ready
//
// a request steps through accept, two dependent synchronous memory reads
// (thread priority, then queue ends / link) with the update written back,
// then a load of the result register; early outs (already ready / not ready)
// skip the write-back step, schedule with all queues empty goes straight to
// the load; one request is in flight at a time
// reset clears ready marks, queue-occupied flags and priority-written flags;
// link and queue-end memories need no clearing, they are only read when occupied
// a held result stalls the sequencer before the final load; no request is accepted meanwhile

module priority_ready_queue_scheduler #(
  parameter int THREADS    = prq_pkg::DEF_THREADS,
  parameter int PRIORITIES = prq_pkg::DEF_PRIORITIES
) (
  input logic      clk,
  input logic      rst,
  prq_req_if.sink  req,
  prq_rsp_if.source rsp
);
  import prq_pkg::*;

  localparam int TW = $clog2(THREADS);
  localparam int PW = $clog2(PRIORITIES);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // thread slot: id reduced into the configured thread count
  function automatic logic [TW-1:0] thread_slot(input logic [2:0] id);
    logic [2:0] v;
    v = id;
    for (int i = 0; i < 4; i++) begin
      if (int'(v) >= THREADS) begin
        v = v - 3'(THREADS);
      end
    end
    return TW'(v);
  endfunction

  // non-negative priority request, clipped to the lowest level
  function automatic logic [PW-1:0] sat_prio(input logic [3:0] v);
    if (int'(v) >= PRIORITIES) begin
      return PW'(PRIORITIES - 1);
    end
    return PW'(v);
  endfunction

  logic [1:0] state;
  logic [1:0] state_next;

  // request held for the duration of the work
  opcode_t         op;
  logic [TW-1:0]   tid;
  logic [4:0]      np;
  logic [PW-1:0]   newp;

  // result waiting for the output register
  logic [2:0]      res_chosen;
  logic [3:0]      res_oldp;
  status_t         res_status;

  // output register
  logic            out_valid;
  logic [2:0]      out_chosen;
  logic [3:0]      out_oldp;
  status_t         out_status;

  // flag bits, cleared by reset
  logic [THREADS-1:0]    ready;
  logic [THREADS-1:0]    prio_ok;
  logic [PRIORITIES-1:0] nonempty;

  // memories: thread priority, successor link, queue head and tail
  logic [PW-1:0]   prio_mem [THREADS];
  logic [TW-1:0]   link_mem [THREADS];
  logic [2*TW-1:0] qend_mem [PRIORITIES];

  logic [PW-1:0]   prio_rd;
  logic            prio_rd_ok;
  logic [TW-1:0]   link_rd;
  logic [2*TW-1:0] qend_rd;

  logic [TW-1:0]   prio_raddr;
  logic [TW-1:0]   link_raddr;
  logic [PW-1:0]   qend_raddr;

  logic            prio_we;
  logic            link_we;
  logic [TW-1:0]   link_waddr;
  logic            qend_we;
  logic [PW-1:0]   qend_waddr;
  logic [2*TW-1:0] qend_wdata;

  // combinational helpers
  logic            accept;
  logic [TW-1:0]   t_in;
  logic            found;
  logic [PW-1:0]   pick;
  logic [PW-1:0]   prio_eff;
  logic [PW-1:0]   newp_calc;
  logic [TW-1:0]   q_head;
  logic [TW-1:0]   q_tail;
  logic            out_free;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign t_in      = thread_slot(req.thread_id);
  assign prio_eff  = prio_rd_ok ? prio_rd : '0;
  assign q_head    = qend_rd[2*TW-1:TW];
  assign q_tail    = qend_rd[TW-1:0];
  assign newp_calc = (op == OP_CHANGE && !np[4]) ? sat_prio(np[3:0]) : prio_eff;
  assign out_free  = !out_valid || rsp.ready;

  // highest occupied level, lowest index wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = PRIORITIES - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        found = 1'b1;
        pick  = PW'(i);
      end
    end
  end

  // read addresses per step
  always_comb begin
    prio_raddr = t_in;
    link_raddr = t_in;
    qend_raddr = pick;
    if (state != S_IDLE) begin
      prio_raddr = (op == OP_SCHEDULE) ? q_head : tid;
      link_raddr = tid;
      qend_raddr = (op == OP_TAKE) ? prio_eff : newp_calc;
    end
  end

  // write-back, all in the second read step
  always_comb begin
    prio_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = q_tail;
    qend_we    = 1'b0;
    qend_waddr = newp;
    qend_wdata = {tid, tid};
    if (state == S_RD2) begin
      unique case (op)
        OP_PUT, OP_CHANGE: begin
          prio_we = 1'b1;
          qend_we = 1'b1;
          if (nonempty[newp]) begin
            // append behind the present tail
            link_we    = 1'b1;
            qend_wdata = {q_head, tid};
          end
        end
        OP_TAKE: begin
          if (q_head == tid && q_tail != tid) begin
            qend_we    = 1'b1;
            qend_wdata = {link_rd, q_tail};
          end
        end
        OP_SCHEDULE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prio_rd    <= prio_mem[prio_raddr];
    prio_rd_ok <= prio_ok[prio_raddr];
    link_rd    <= link_mem[link_raddr];
    qend_rd    <= qend_mem[qend_raddr];
    if (prio_we) begin
      prio_mem[tid] <= newp;
    end
    if (link_we) begin
      link_mem[link_waddr] <= tid;
    end
    if (qend_we) begin
      qend_mem[qend_waddr] <= qend_wdata;
    end
  end

  // sequencer and result forming
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.opcode == OP_SCHEDULE && !found) ? S_OUT : S_RD1;
        end
      end
      S_RD1: begin
        unique case (op)
          OP_PUT, OP_CHANGE: state_next = ready[tid] ? S_OUT : S_RD2;
          OP_TAKE:           state_next = (ready[tid] && nonempty[prio_eff]) ? S_RD2 : S_OUT;
          OP_SCHEDULE:       state_next = S_RD2;
          default:           state_next = S_OUT;
        endcase
      end
      S_RD2: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= '0;
      prio_ok   <= '0;
      nonempty  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (prio_we) begin
        prio_ok[tid] <= 1'b1;
      end
      if (state == S_RD2) begin
        unique case (op)
          OP_PUT, OP_CHANGE: begin
            nonempty[newp] <= 1'b1;
            ready[tid]     <= 1'b1;
          end
          OP_TAKE: begin
            if (q_head == tid) begin
              ready[tid] <= 1'b0;
              if (q_tail == tid) begin
                nonempty[newp] <= 1'b0;
              end
            end
          end
          OP_SCHEDULE: begin
          end
          default: begin
          end
        endcase
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op  <= req.opcode;
          tid <= t_in;
          np  <= req.new_priority;
          // empty schedule finishes here
          res_chosen <= '0;
          res_oldp   <= '0;
          res_status <= ST_NONE_READY;
        end
      end
      S_RD1: begin
        unique case (op)
          OP_PUT, OP_CHANGE: begin
            newp       <= newp_calc;
            res_chosen <= 3'(tid);
            res_oldp   <= 4'(prio_eff);
            res_status <= ready[tid] ? ST_ALREADY : ST_DONE;
          end
          OP_TAKE: begin
            newp       <= prio_eff;
            res_chosen <= 3'(tid);
            res_oldp   <= 4'(prio_eff);
            if (!ready[tid]) begin
              res_status <= ST_ALREADY;
            end else if (!nonempty[prio_eff]) begin
              res_status <= ST_NOT_HEAD;
            end else begin
              res_status <= ST_DONE;
            end
          end
          OP_SCHEDULE: begin
            // priority of the head follows in the next step
            res_chosen <= 3'(q_head);
            res_status <= ST_DONE;
          end
          default: begin
          end
        endcase
      end
      S_RD2: begin
        unique case (op)
          OP_TAKE: begin
            if (q_head != tid) begin
              res_status <= ST_NOT_HEAD;
            end
          end
          OP_SCHEDULE: begin
            // priority of the picked head, read with its address
            res_oldp <= 4'(prio_eff);
          end
          OP_PUT, OP_CHANGE: begin
          end
          default: begin
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_chosen <= res_chosen;
          out_oldp   <= res_oldp;
          out_status <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid         = out_valid;
  assign rsp.chosen_thread = out_chosen;
  assign rsp.old_priority  = out_oldp;
  assign rsp.status        = out_status;

  // one request in flight
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while one is in flight");

  // no more queues are occupied than threads are ready
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    $countones(nonempty) <= $countones(ready))
    else $error("more occupied queues than ready threads");

  // memory updates only in the write-back step
  a_write_step: assert property (@(posedge clk) disable iff (rst)
    (prio_we || link_we || qend_we) |-> state == S_RD2)
    else $error("memory written outside write-back");

  // a free result register never holds the sequencer
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_valid) |=> (state == S_IDLE && out_valid))
    else $error("result not loaded into a free output register");

endmodule
